>>> sv/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared types and constants for the 64-bit modular exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

    localparam int WORD_BITS = 64;
    localparam int CNT_BITS  = $clog2(WORD_BITS);

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [CNT_BITS-1:0]  t_cnt;

    typedef struct packed {
        t_word base_value;
        t_word exponent_value;
        t_word modulus_value;
    } t_in;

    typedef struct packed {
        t_word power_result;
        logic  zero_modulus_error;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RED,
        ST_NEXT,
        ST_DBL,
        ST_ADD
    } t_state;

endpackage

>>> sv/mexp_addmod.sv
// ----------------------------------------------------------------------------
// mexp_addmod
// Shared modular adder: (x + y + cin) mod m for x, y < m, one conditional
// subtract, carry-safe across the full word.
// ----------------------------------------------------------------------------
module mexp_addmod (
    input  mexp_pkg::t_word i_x,
    input  mexp_pkg::t_word i_y,
    input  logic            i_cin,
    input  mexp_pkg::t_word i_m,
    output mexp_pkg::t_word o_sum
);

    logic [mexp_pkg::WORD_BITS:0] w_sum;
    logic [mexp_pkg::WORD_BITS:0] w_dif;

    // wide sum, then reduce once
    always_comb begin
        w_sum = {1'b0, i_x} + {1'b0, i_y} + {{mexp_pkg::WORD_BITS{1'b0}}, i_cin};
        w_dif = w_sum - {1'b0, i_m};
        if (w_sum >= {1'b0, i_m}) begin
            o_sum = w_dif[mexp_pkg::WORD_BITS-1:0];
        end else begin
            o_sum = w_sum[mexp_pkg::WORD_BITS-1:0];
        end
    end

endmodule

>>> sv/modular_exponentiation_64.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_64
// Computes base^exponent mod modulus by right-to-left square-and-multiply.
// ----------------------------------------------------------------------------
// Pulse i_start with an item while o_busy is low; the result appears on o_out
// for one cycle marked by o_valid and cannot be held off. All arithmetic runs
// through one modular adder, one add per cycle: base reduction shifts in the
// base one bit at a time from the top, each modular multiply doubles for every
// multiplier bit and adds for each set one, and each exponent bit up to the
// highest set one costs a select step, a squaring, and a multiply when set. A
// zero modulus strobes the cycle after the transfer, and a zero exponent still
// runs the base reduction. Zero modulus returns 0 with the error flag set.
module modular_exponentiation_64 (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  mexp_pkg::t_in    i_in,
    output logic             o_busy,
    output logic             o_valid,
    output mexp_pkg::t_out   o_out
);

    mexp_pkg::t_state r_state, n_state;
    mexp_pkg::t_word  r_m, n_m, r_b, n_b, r_e, n_e, r_acc, n_acc;
    mexp_pkg::t_word  r_a, n_a, r_mb, n_mb, r_r, n_r;
    mexp_pkg::t_cnt   r_cnt, n_cnt;
    logic             r_sqr, n_sqr;
    logic             r_valid, n_valid;
    mexp_pkg::t_out   r_out, n_out;

    mexp_pkg::t_word  w_x, w_y, w_sum;
    logic             w_cin;

    mexp_addmod u_add (
        .i_x   (w_x),
        .i_y   (w_y),
        .i_cin (w_cin),
        .i_m   (r_m),
        .o_sum (w_sum)
    );

    // operand selection for the shared adder
    always_comb begin
        w_x   = r_r;
        w_y   = r_r;
        w_cin = 1'b0;
        case (r_state)
            mexp_pkg::ST_RED: begin
                w_cin = r_mb[mexp_pkg::WORD_BITS-1];
            end
            mexp_pkg::ST_ADD: begin
                w_y = r_a;
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_comb begin
        logic advance;
        logic [mexp_pkg::WORD_BITS-1:0] prod;
        advance = 1'b0;
        prod    = w_sum;
        n_state = r_state;
        n_m     = r_m;
        n_b     = r_b;
        n_e     = r_e;
        n_acc   = r_acc;
        n_a     = r_a;
        n_mb    = r_mb;
        n_r     = r_r;
        n_cnt   = r_cnt;
        n_sqr   = r_sqr;
        n_valid = 1'b0;
        n_out   = r_out;
        case (r_state)
            mexp_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_m  = i_in.modulus_value;
                    n_e  = i_in.exponent_value;
                    n_mb = i_in.base_value;
                    n_r  = '0;
                    n_cnt = '1;
                    if (i_in.modulus_value == '0) begin
                        n_valid = 1'b1;
                        n_out.power_result       = '0;
                        n_out.zero_modulus_error = 1'b1;
                    end else begin
                        n_state = mexp_pkg::ST_RED;
                    end
                end
            end
            // base mod m, one bit per cycle from the top
            mexp_pkg::ST_RED: begin
                n_r  = w_sum;
                n_mb = r_mb << 1;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_b   = w_sum;
                    n_acc = (r_m == mexp_pkg::t_word'(1)) ? '0 : mexp_pkg::t_word'(1);
                    n_state = mexp_pkg::ST_NEXT;
                end
            end
            // pick the next multiply for the current exponent bit
            mexp_pkg::ST_NEXT: begin
                n_r   = '0;
                n_cnt = '1;
                if (r_e == '0) begin
                    n_valid = 1'b1;
                    n_out.power_result       = r_acc;
                    n_out.zero_modulus_error = 1'b0;
                    n_state = mexp_pkg::ST_IDLE;
                end else if (r_e[0]) begin
                    n_a   = r_acc;
                    n_mb  = r_b;
                    n_sqr = 1'b0;
                    n_state = mexp_pkg::ST_DBL;
                end else begin
                    n_a   = r_b;
                    n_mb  = r_b;
                    n_sqr = 1'b1;
                    n_state = mexp_pkg::ST_DBL;
                end
            end
            mexp_pkg::ST_DBL: begin
                n_r = w_sum;
                if (r_mb[mexp_pkg::WORD_BITS-1]) begin
                    n_state = mexp_pkg::ST_ADD;
                end else begin
                    advance = 1'b1;
                end
            end
            mexp_pkg::ST_ADD: begin
                n_r     = w_sum;
                advance = 1'b1;
            end
            default: begin
                n_state = mexp_pkg::ST_IDLE;
            end
        endcase

        // step to the next multiplier bit, or close the multiply
        if (advance) begin
            n_mb  = r_mb << 1;
            n_cnt = r_cnt - 1'b1;
            n_state = mexp_pkg::ST_DBL;
            if (r_cnt == '0) begin
                n_r   = '0;
                n_cnt = '1;
                if (r_sqr) begin
                    n_b = prod;
                    n_e = r_e >> 1;
                    n_state = mexp_pkg::ST_NEXT;
                end else begin
                    n_acc = prod;
                    n_a   = r_b;
                    n_mb  = r_b;
                    n_sqr = 1'b1;
                end
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mexp_pkg::ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_m   <= n_m;
        r_b   <= n_b;
        r_e   <= n_e;
        r_acc <= n_acc;
        r_a   <= n_a;
        r_mb  <= n_mb;
        r_r   <= n_r;
        r_cnt <= n_cnt;
        r_sqr <= n_sqr;
        r_out <= n_out;
    end

    assign o_busy  = (r_state != mexp_pkg::ST_IDLE);
    assign o_valid = r_valid;
    assign o_out   = r_out;

endmodule
